// File: hw/rtl/rgb2gray_pkg.sv
// Shared types, mode codes and fixed-point weights for the RGB to gray converter.
`timescale 1ns / 1ps
`default_nettype none

package rgb2gray_pkg;

  localparam int WEIGHT_W = 16;

  // Q16 channel weights, index 0 is red, 1 green, 2 blue.
  localparam logic [2:0][WEIGHT_W-1:0] NTSC_W = {16'd7503, 16'd38444, 16'd19589};
  localparam logic [2:0][WEIGHT_W-1:0] HDTV_W = {16'd4675, 16'd46311, 16'd14550};

  // ceil(2^16 / 3): exact floor division by three for sums below 766.
  localparam logic [WEIGHT_W-1:0] DIV3_RECIP = 16'd21846;
  localparam logic [WEIGHT_W-1:0] UNIT_W     = 16'd1;

  typedef enum logic [1:0] {
    MODE_COLOR = 2'd0,
    MODE_NTSC  = 2'd1,
    MODE_AVG   = 2'd2,
    MODE_HDTV  = 2'd3
  } mode_t;

  typedef enum logic [4:0] {
    ST_IDLE   = 5'b00001,
    ST_MAC    = 5'b00010,
    ST_DIV    = 5'b00100,
    ST_SEARCH = 5'b01000,
    ST_FINISH = 5'b10000
  } state_t;

  // Weight applied to channel idx during the multiply-accumulate pass.
  function automatic logic [WEIGHT_W-1:0] chan_weight(mode_t mode, logic [1:0] idx);
    logic [WEIGHT_W-1:0] w;
    w = UNIT_W;
    case (mode)
      MODE_NTSC: begin
        case (idx)
          2'd0:    w = NTSC_W[0];
          2'd1:    w = NTSC_W[1];
          default: w = NTSC_W[2];
        endcase
      end
      MODE_HDTV: begin
        case (idx)
          2'd0:    w = HDTV_W[0];
          2'd1:    w = HDTV_W[1];
          default: w = HDTV_W[2];
        endcase
      end
      default: w = UNIT_W;
    endcase
    return w;
  endfunction

endpackage

`default_nettype wire

// File: hw/rtl/rgb_to_gray_multi_mode.sv
// RGB to gray converter with colour, NTSC, average and HDTV gamma modes.
// A new word is accepted only while the sequencer is idle; the next word can start while
// one waits at the output. The pace is set by the shared multiply-accumulate unit
// (three channel passes) and the eight-step search over the power table.
// Synchronous active-high reset returns the sequencer to idle, clears output valid
// and sets the mode register to colour passthrough.
`timescale 1ns / 1ps
`default_nettype none

module rgb_to_gray_multi_mode #(
  parameter int POWER_FRAC_BITS = 12
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       cfg_wr_en,
  input  wire logic [1:0] cfg_wr_data,
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire logic [7:0] red,
  input  wire logic [7:0] green,
  input  wire logic [7:0] blue,
  output logic            out_valid,
  input  wire logic       out_stall,
  output logic [7:0]      gray,
  output logic            is_gray
);

  // Power table entries hold x^1.075 with POWER_FRAC_BITS fraction bits; 255^1.075 < 2^9.
  localparam int PW    = POWER_FRAC_BITS + 9;
  localparam int ACC_W = PW + rgb2gray_pkg::WEIGHT_W;
  localparam int BIG_W = 40 * PW + 64;

  function automatic logic [BIG_W-1:0] pow40(logic [BIG_W-1:0] y);
    logic [BIG_W-1:0] p;
    p = BIG_W'(1);
    for (int k = 0; k < 40; k++) begin
      p = p * y;
    end
    return p;
  endfunction

  // Floating estimate, then an exact integer check: largest y with y^40 <= x^43 * 2^(40F).
  function automatic logic [255:0][PW-1:0] build_pow_rom();
    logic [255:0][PW-1:0] rom;
    logic [BIG_W-1:0]     target;
    real                  approx;
    int                   est;
    for (int x = 0; x < 256; x++) begin
      target = BIG_W'(1) << (40 * POWER_FRAC_BITS);
      for (int k = 0; k < 43; k++) begin
        target = target * BIG_W'(x);
      end
      approx = $pow(real'(x), 1.075) * $pow(2.0, real'(POWER_FRAC_BITS));
      est = $rtoi(approx);
      for (int k = 0; k < 2; k++) begin
        if (pow40(BIG_W'(est + 1)) <= target) begin
          est = est + 1;
        end
      end
      for (int k = 0; k < 2; k++) begin
        if (est > 0 && pow40(BIG_W'(est)) > target) begin
          est = est - 1;
        end
      end
      rom[x] = PW'(est);
    end
    return rom;
  endfunction

  localparam logic [255:0][PW-1:0] POW_ROM = build_pow_rom();

  rgb2gray_pkg::state_t state;
  rgb2gray_pkg::state_t state_next;
  rgb2gray_pkg::mode_t  gray_mode;

  logic [7:0]       red_q;
  logic [7:0]       green_q;
  logic [7:0]       blue_q;
  logic [1:0]       idx;
  logic [ACC_W-1:0] acc;
  logic [7:0]       cand;
  logic [7:0]       bit_mask;

  logic [7:0]                      chan_sel;
  logic [7:0]                      trial;
  logic [7:0]                      rom_idx;
  logic [PW-1:0]                   rom_data;
  logic [rgb2gray_pkg::WEIGHT_W-1:0] weight;
  logic [PW-1:0]                   operand;
  logic [ACC_W-1:0]                product;
  logic                            fits;
  logic [PW-1:0]                   acc_hi;
  logic [7:0]                      sat_gray;
  logic                            in_take;
  logic                            out_free;

  assign in_stall = (state != rgb2gray_pkg::ST_IDLE);
  assign in_take  = in_valid && !in_stall;
  assign out_free = !out_valid || !out_stall;

  always_comb begin
    case (idx)
      2'd0:    chan_sel = red_q;
      2'd1:    chan_sel = green_q;
      default: chan_sel = blue_q;
    endcase
  end

  assign trial    = cand | bit_mask;
  assign rom_idx  = (state == rgb2gray_pkg::ST_SEARCH) ? trial : chan_sel;
  assign rom_data = POW_ROM[rom_idx];

  // The one multiplier serves the channel passes and the divide by three.
  always_comb begin
    if (state == rgb2gray_pkg::ST_DIV) begin
      weight  = rgb2gray_pkg::DIV3_RECIP;
      operand = PW'(acc[9:0]);
    end else begin
      weight  = rgb2gray_pkg::chan_weight(gray_mode, idx);
      operand = (gray_mode == rgb2gray_pkg::MODE_HDTV) ? rom_data : PW'(chan_sel);
    end
  end

  assign product = ACC_W'(weight) * ACC_W'(operand);
  assign fits    = {rom_data, 16'b0} <= acc;
  assign acc_hi  = acc[ACC_W-1:16];
  assign sat_gray = (|acc_hi[PW-1:8]) ? 8'hFF : acc_hi[7:0];

  always_comb begin
    state_next = state;
    case (state)
      rgb2gray_pkg::ST_IDLE: begin
        if (in_take) begin
          state_next = (gray_mode == rgb2gray_pkg::MODE_COLOR) ?
                       rgb2gray_pkg::ST_FINISH : rgb2gray_pkg::ST_MAC;
        end
      end
      rgb2gray_pkg::ST_MAC: begin
        if (idx == 2'd2) begin
          case (gray_mode)
            rgb2gray_pkg::MODE_AVG:  state_next = rgb2gray_pkg::ST_DIV;
            rgb2gray_pkg::MODE_HDTV: state_next = rgb2gray_pkg::ST_SEARCH;
            default:                 state_next = rgb2gray_pkg::ST_FINISH;
          endcase
        end
      end
      rgb2gray_pkg::ST_DIV:    state_next = rgb2gray_pkg::ST_FINISH;
      rgb2gray_pkg::ST_SEARCH: begin
        if (bit_mask[0]) begin
          state_next = rgb2gray_pkg::ST_FINISH;
        end
      end
      rgb2gray_pkg::ST_FINISH: begin
        if (out_free) begin
          state_next = rgb2gray_pkg::ST_IDLE;
        end
      end
      default: state_next = rgb2gray_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= rgb2gray_pkg::ST_IDLE;
      gray_mode <= rgb2gray_pkg::MODE_COLOR;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_wr_en) begin
        gray_mode <= rgb2gray_pkg::mode_t'(cfg_wr_data);
      end
      if (state == rgb2gray_pkg::ST_FINISH && out_free) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      rgb2gray_pkg::ST_IDLE: begin
        if (in_take) begin
          red_q   <= red;
          green_q <= green;
          blue_q  <= blue;
          acc     <= '0;
          idx     <= 2'd0;
        end
      end
      rgb2gray_pkg::ST_MAC: begin
        acc      <= acc + product;
        idx      <= idx + 2'd1;
        cand     <= 8'd0;
        bit_mask <= 8'h80;
      end
      rgb2gray_pkg::ST_DIV: begin
        acc <= product;
      end
      rgb2gray_pkg::ST_SEARCH: begin
        if (fits) begin
          cand <= trial;
        end
        bit_mask <= bit_mask >> 1;
      end
      rgb2gray_pkg::ST_FINISH: begin
        if (out_free) begin
          case (gray_mode)
            rgb2gray_pkg::MODE_COLOR: begin
              gray    <= 8'd0;
              is_gray <= 1'b0;
            end
            rgb2gray_pkg::MODE_HDTV: begin
              gray    <= cand;
              is_gray <= 1'b1;
            end
            default: begin
              gray    <= sat_gray;
              is_gray <= 1'b1;
            end
          endcase
        end
      end
      default: begin
        idx <= idx;
      end
    endcase
  end

  // The search walks one bit at a time, so exactly one trial bit is set.
  assert property (@(posedge clk) disable iff (rst)
    state == rgb2gray_pkg::ST_SEARCH |-> $onehot(bit_mask))
    else $error("search bit mask is not one-hot");

  // A colour-mode word skips the arithmetic and goes straight to the output stage.
  assert property (@(posedge clk) disable iff (rst)
    in_take && gray_mode == rgb2gray_pkg::MODE_COLOR |=> state == rgb2gray_pkg::ST_FINISH)
    else $error("colour-mode word did not go straight to finish");

  // A word with no gray level always carries a zero gray field.
  assert property (@(posedge clk) disable iff (rst)
    out_valid && !is_gray |-> gray == 8'd0)
    else $error("colour-mode word has a nonzero gray field");

  // The channel pass never runs past the blue channel.
  assert property (@(posedge clk) disable iff (rst)
    state == rgb2gray_pkg::ST_MAC |-> idx != 2'd3)
    else $error("channel index out of range");

endmodule

`default_nettype wire
